### design/sth64_pkg.sv
// package for the truncated sha-256 core: round constants, initial hash and helper functions
`timescale 1ns / 1ps
package sth64_pkg;

	localparam int Rounds = 64;
	localparam int WinDepth = 16;

	localparam logic [31:0] H_INIT [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [31:0] LEN_WORD = 32'd64;

	localparam logic [31:0] K_TABLE [0:Rounds-1] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### design/sha256_truncated_hash64_top.sv
// top level: iterative one-block sha-256 of a 64-bit message, first digest word out
`timescale 1ns / 1ps
// Hashes a 64-bit message as one padded sha-256 block and returns the first digest word.
// A transaction is taken when start is high and busy is low. The core then runs one
// compression round per cycle through a single shared round unit, with the message
// schedule expanded alongside in a sixteen-word shift window, then a finish state
// adds H0 to the first working word. digest_word is valid for exactly one cycle while
// done is high, after the finish state; busy falls in that same cycle, so the next
// message can be taken there, but none while one is in flight. The receiver
// cannot stall the result and must take it in the cycle that done is high.
module sha256_truncated_hash64_top
	import sth64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] message,
	output logic        done,
	output logic [31:0] digest_word
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t      state_q;
	logic [5:0]  round_q;
	logic [31:0] win_q [0:WinDepth-1];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic        accept;
	logic [31:0] t1, t2, ch, maj, w_next;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	// round unit
	assign ch     = (e_q & f_q) ^ (~e_q & g_q);
	assign maj    = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
	assign t1     = h_q + big_sigma1(e_q) + ch + K_TABLE[round_q] + win_q[0];
	assign t2     = big_sigma0(a_q) + maj;
	// schedule word sixteen ahead of the current one
	assign w_next = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(Rounds - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= message[63:32];
			win_q[1] <= message[31:0];
			win_q[2] <= PAD_WORD;
			for (int i = 3; i < WinDepth - 1; i++) begin
				win_q[i] <= '0;
			end
			win_q[WinDepth-1] <= LEN_WORD;
			a_q <= H_INIT[0];
			b_q <= H_INIT[1];
			c_q <= H_INIT[2];
			d_q <= H_INIT[3];
			e_q <= H_INIT[4];
			f_q <= H_INIT[5];
			g_q <= H_INIT[6];
			h_q <= H_INIT[7];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < WinDepth - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinDepth-1] <= w_next;
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
		if (state_q == ST_FINISH) begin
			digest_word <= H_INIT[0] + a_q;
		end
	end

endmodule

### sim/sth64_digest_checker.sv
// checker for the truncated sha-256 core: predicts the first digest word and compares results
`timescale 1ns / 1ps
module sth64_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] message,
	input  logic        done,
	input  logic [31:0] digest_word,
	output int          errors,
	output int          pending
);

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0] digest_due [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
		return (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [31:0] first_digest_word(input logic [63:0] msg);
		logic [31:0] w [0:63];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] s0, s1, t1, t2;
		for (int r = 0; r < 64; r++)
			w[r] = 32'h0;
		// single padded block: message, 0x80 marker, zeros, bit length
		w[0] = msg[63:32];
		w[1] = msg[31:0];
		w[2] = 32'h80000000;
		w[15] = 32'd64;
		for (int r = 16; r < 64; r++) begin
			s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
			s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
			w[r] = w[r-16] + s0 + w[r-7] + s1;
		end
		a = IV[0]; b = IV[1]; c = IV[2]; d = IV[3];
		e = IV[4]; f = IV[5]; g = IV[6]; h = IV[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[r] + w[r];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		return IV[0] + a;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			// result first: a new transaction may be taken on the edge that ends done
			if (done) begin
				if (digest_due.size() == 0) begin
					$error("digest_word: unexpected result 0x%08h", digest_word);
					errors = errors + 1;
				end else begin
					want = digest_due.pop_front();
					if (digest_word !== want) begin
						$error("digest_word: expected 0x%08h, actual 0x%08h", want, digest_word);
						errors = errors + 1;
					end
				end
			end
			if (start && !busy)
				digest_due.push_back(first_digest_word(message));
			pending = digest_due.size();
		end
	end

endmodule

### sim/tb_top.sv
// testbench top for the truncated sha-256 core: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;

	localparam int IdleLimit = 2000;
	localparam int RandPerPhase = 295;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] message;
	logic        done;
	logic [31:0] digest_word;
	int          errors;
	int          pending;
	int          stall_cnt;
	int          idle_pct;

	sha256_truncated_hash64_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.message     (message),
		.done        (done),
		.digest_word (digest_word)
	);

	sth64_digest_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.message     (message),
		.done        (done),
		.digest_word (digest_word),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: cycles with no transaction and no result
	initial stall_cnt = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cnt = 0;
			else
				stall_cnt = stall_cnt + 1;
			if (stall_cnt >= IdleLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at the first falling edge after acceptance with busy low
	task automatic push_message(input logic [63:0] m);
		start <= 1'b1;
		message <= m;
		@(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic hold_off();
		start <= 1'b0;
		message <= {$urandom, $urandom};
		@(negedge clk);
	endtask

	function automatic logic [63:0] random_message();
		logic [63:0] m;
		m = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: m = m & {{56{1'b0}}, 8'hff};
			1: m = m | {{32{1'b1}}, 32'h0};
			2: m = m & {$urandom, $urandom} & {$urandom, $urandom};
			3: m = m | {$urandom, $urandom} | {$urandom, $urandom};
			default: ;
		endcase
		return m;
	endfunction

	initial begin
		logic [63:0] directed [$];
		arst_n = 1'b0;
		start = 1'b0;
		message = 64'h0;
		idle_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000000, 64'h1,
			64'hffffffff00000000, 64'h00000000ffffffff, 64'h5555555555555555,
			64'haaaaaaaaaaaaaaaa, 64'h0000000100000000, 64'h0000000080000000,
			64'h7fffffffffffffff, 64'hfffffffffffffffe, 64'h0123456789abcdef,
			64'hfedcba9876543210, 64'h6162630000000000};
		foreach (directed[i])
			push_message(directed[i]);

		// pause until the core has drained
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
			for (int n = 0; n < RandPerPhase; n++) begin
				while ($urandom_range(0, 99) < idle_pct)
					hold_off();
				push_message(random_message());
			end
		end
		start <= 1'b0;
		@(negedge clk);

		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
